FILE: hdl/pb64_pkg.sv
// Shared types, constants and the Base64 alphabet lookup for the prefixed decoder.
`timescale 1ns / 1ps

package pb64_pkg;

	localparam int unsigned PrefixLen = 4;

	// "B64:" with the first character in entry 0
	localparam logic [PrefixLen-1:0][7:0] PREFIX_CHARS = {8'h3A, 8'h34, 8'h36, 8'h42};

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic [1:0] {
		ST_DECODED     = 2'd0,
		ST_PASSTHROUGH = 2'd1,
		ST_FAILED      = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_result;
		status_t    status;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	// Map one character of the standard alphabet to its six-bit value
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		case (c) inside
			[8'h41:8'h5A]: s.value = 6'(c - 8'h41);
			[8'h61:8'h7A]: s.value = 6'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: s.value = 6'(c - 8'h30 + 8'd52);
			8'h2B:         s.value = 6'd62;
			8'h2F:         s.value = 6'd63;
			default:       s.valid = 1'b0;
		endcase
		return s;
	endfunction

endpackage

FILE: hdl/pb64_char_if.sv
// Character channel: one string character per transaction.
`timescale 1ns / 1ps

interface pb64_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       final_char;

	modport source (output valid, output char_code, output final_char, input ready);
	modport sink (input valid, input char_code, input final_char, output ready);
endinterface

FILE: hdl/pb64_result_if.sv
// Result channel: one decoded or passed-through byte, or an end marker, per transaction.
`timescale 1ns / 1ps

interface pb64_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_result;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_valid, output last_result,
		output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input last_result,
		input status, output ready);
endinterface

FILE: hdl/prefixed_base64_decoder.sv
// Top level of the prefixed Base64 decoder.
`timescale 1ns / 1ps

// Strings arrive one character per transaction on char_stream, with final_char on the last.
// A string that opens with "B64:" is decoded as standard Base64 and yields one byte per
// completed byte of the body; anything else is passed through byte for byte, and the prefix
// characters held so far are replayed when the mismatch shows up. The last result of every
// string carries last_result and a status (decoded, passthrough, failed); on failed the
// receiver discards the string's bytes. A character is registered, evaluated against the
// decoder state and written into a four-entry result buffer, so one character is taken every
// cycle as long as each yields at most one result and the sink keeps up.
// A prefix mismatch yields up to four results, which the buffer drains one per cycle while
// the sink is ready; the character stream stalls until the last buffered result is taken.

module prefixed_base64_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	pb64_char_if.sink            char_stream,
	pb64_result_if.source        result_stream
);

	localparam int unsigned BufDepth = pb64_pkg::PrefixLen;

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;

	// Decoder state
	logic [2:0] prefix_count_q;
	logic       passthrough_q;
	logic [5:0] residue_q;
	logic [1:0] phase_q;
	logic       padding_q;
	logic       failed_q;
	logic       any_byte_q;

	// Result buffer, entry 0 is the head
	pb64_pkg::result_t   buf_q [BufDepth];
	logic [2:0]          buf_cnt_q;

	// Evaluation of the registered character
	pb64_pkg::result_t   res   [BufDepth];
	logic [2:0]          res_cnt;
	logic [2:0]          prefix_count_d;
	logic                passthrough_d;
	logic [5:0]          residue_d;
	logic [1:0]          phase_d;
	logic                padding_d;
	logic                failed_d;
	logic                any_byte_d;

	logic                pop;
	logic                buf_free;
	logic                consume;
	logic                take;

	logic [1:0]          held;
	logic                match;
	pb64_pkg::sextet_t   sx;
	logic                have;
	logic [7:0]          dec_byte;
	pb64_pkg::status_t   cur_status;

	assign pop      = result_stream.valid && result_stream.ready;
	assign buf_free = (buf_cnt_q == 3'd0) || ((buf_cnt_q == 3'd1) && pop);
	assign consume  = valid_s1 && ((res_cnt == 3'd0) || buf_free);
	assign take     = char_stream.valid && char_stream.ready;

	assign char_stream.ready = !valid_s1 || consume;

	assign result_stream.valid       = (buf_cnt_q != 3'd0);
	assign result_stream.out_byte    = buf_q[0].out_byte;
	assign result_stream.byte_valid  = buf_q[0].byte_valid;
	assign result_stream.last_result = buf_q[0].last_result;
	assign result_stream.status      = buf_q[0].status;

	assign held       = prefix_count_q[1:0];
	assign match      = (char_s1 == pb64_pkg::PREFIX_CHARS[held]);
	assign sx         = pb64_pkg::sextet_of(char_s1);
	assign cur_status = final_s1 ? pb64_pkg::ST_PASSTHROUGH : pb64_pkg::ST_DECODED;

	always_comb begin
		prefix_count_d = prefix_count_q;
		passthrough_d  = passthrough_q;
		residue_d      = residue_q;
		phase_d        = phase_q;
		padding_d      = padding_q;
		failed_d       = failed_q;
		any_byte_d     = any_byte_q;
		have           = 1'b0;
		dec_byte       = 8'd0;
		res_cnt        = 3'd0;
		for (int i = 0; i < BufDepth; i++) begin
			res[i] = '{out_byte: 8'd0, byte_valid: 1'b0, last_result: 1'b0,
				status: pb64_pkg::ST_DECODED};
		end

		if (passthrough_q) begin
			res[0]  = '{out_byte: char_s1, byte_valid: 1'b1, last_result: final_s1,
				status: cur_status};
			res_cnt = 3'd1;
		end else if (!prefix_count_q[2]) begin
			if (match && (held == 2'd3)) begin
				prefix_count_d = 3'd4;
				if (final_s1) begin
					res[0]  = '{out_byte: 8'd0, byte_valid: 1'b0, last_result: 1'b1,
						status: pb64_pkg::ST_DECODED};
					res_cnt = 3'd1;
				end
			end else if (match && !final_s1) begin
				prefix_count_d = prefix_count_q + 3'd1;
			end else begin
				// Replay the held prefix characters, then the current one
				for (int i = 0; i < BufDepth; i++) begin
					if (i < int'(held)) begin
						res[i] = '{out_byte: pb64_pkg::PREFIX_CHARS[i], byte_valid: 1'b1,
							last_result: 1'b0, status: pb64_pkg::ST_DECODED};
					end else if (i == int'(held)) begin
						res[i] = '{out_byte: char_s1, byte_valid: 1'b1,
							last_result: final_s1, status: cur_status};
					end
				end
				res_cnt       = {1'b0, held} + 3'd1;
				passthrough_d = 1'b1;
			end
		end else begin
			if (!padding_q && !failed_q) begin
				if (char_s1 == pb64_pkg::PAD_CHAR) begin
					padding_d = 1'b1;
				end else if (!sx.valid) begin
					failed_d = 1'b1;
				end else begin
					case (phase_q)
						2'd0: begin
							residue_d = sx.value;
						end
						2'd1: begin
							dec_byte  = {residue_q, sx.value[5:4]};
							residue_d = {2'b00, sx.value[3:0]};
							have      = 1'b1;
						end
						2'd2: begin
							dec_byte  = {residue_q[3:0], sx.value[5:2]};
							residue_d = {4'b0000, sx.value[1:0]};
							have      = 1'b1;
						end
						default: begin
							dec_byte  = {residue_q[1:0], sx.value};
							residue_d = 6'd0;
							have      = 1'b1;
						end
					endcase
					phase_d = phase_q + 2'd1;
					if (have) begin
						any_byte_d = 1'b1;
					end
				end
			end
			if (final_s1) begin
				res[0]  = '{out_byte: dec_byte, byte_valid: have, last_result: 1'b1,
					status: (failed_d || !any_byte_d) ? pb64_pkg::ST_FAILED
						: pb64_pkg::ST_DECODED};
				res_cnt = 3'd1;
			end else if (have) begin
				res[0]  = '{out_byte: dec_byte, byte_valid: 1'b1, last_result: 1'b0,
					status: pb64_pkg::ST_DECODED};
				res_cnt = 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1  <= char_stream.char_code;
			final_s1 <= char_stream.final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_count_q <= 3'd0;
			passthrough_q  <= 1'b0;
			residue_q      <= 6'd0;
			phase_q        <= 2'd0;
			padding_q      <= 1'b0;
			failed_q       <= 1'b0;
			any_byte_q     <= 1'b0;
		end else if (consume) begin
			if (final_s1) begin
				// End of string: back to the reset state
				prefix_count_q <= 3'd0;
				passthrough_q  <= 1'b0;
				residue_q      <= 6'd0;
				phase_q        <= 2'd0;
				padding_q      <= 1'b0;
				failed_q       <= 1'b0;
				any_byte_q     <= 1'b0;
			end else begin
				prefix_count_q <= prefix_count_d;
				passthrough_q  <= passthrough_d;
				residue_q      <= residue_d;
				phase_q        <= phase_d;
				padding_q      <= padding_d;
				failed_q       <= failed_d;
				any_byte_q     <= any_byte_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= 3'd0;
		end else if (consume && (res_cnt != 3'd0)) begin
			buf_cnt_q <= res_cnt;
		end else if (pop) begin
			buf_cnt_q <= buf_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && (res_cnt != 3'd0)) begin
			for (int i = 0; i < BufDepth; i++) begin
				buf_q[i] <= res[i];
			end
		end else if (pop) begin
			// Advance the queue by one entry
			for (int i = 0; i < BufDepth - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

endmodule

FILE: hdl/pb64_checker.sv
// Port-level checks on the prefixed Base64 decoder and their bind to the top level.
`timescale 1ns / 1ps

module pb64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last_result,
	input logic [1:0] status
);

	// Hold a stalled result transaction unchanged
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(byte_valid)
			&& $stable(last_result) && $stable(status))
		else $error("result changed while stalled");

	// Only the last result of a string carries a status
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_result |-> status == pb64_pkg::ST_DECODED)
		else $error("status on a result that is not last");

	// An end marker without a byte is always the last result
	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !byte_valid |-> last_result && out_byte == 8'd0)
		else $error("empty result that is not a clean end marker");

	// Status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> status == pb64_pkg::ST_DECODED || status == pb64_pkg::ST_PASSTHROUGH
			|| status == pb64_pkg::ST_FAILED)
		else $error("unused status code");

endmodule

bind prefixed_base64_decoder pb64_checker u_pb64_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result_stream.valid),
	.ready       (result_stream.ready),
	.out_byte    (result_stream.out_byte),
	.byte_valid  (result_stream.byte_valid),
	.last_result (result_stream.last_result),
	.status      (result_stream.status)
);

FILE: bench/tb_top.sv
// Self-checking bench for the prefixed Base64 decoder: directed table, then random strings.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned DIRECTED_LEN = 25;
	localparam int unsigned RANDOM_ITEMS = 105;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 20;

	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_LOWZ  = 8'h7A;

	typedef struct packed {
		logic [7:0]         code;
		logic               fin;
		logic               typed;
		pb64_pkg::result_t  want;
	} char_item_t;

	localparam pb64_pkg::result_t NO_RES = '0;

	// Typed expectations only on rows whose single result is obvious
	localparam char_item_t DIRECTED_ROWS [DIRECTED_LEN] = '{
		// prefix alone: end marker, decoded
		'{CH_B, 1'b0, 1'b0, NO_RES},
		'{CH_6, 1'b0, 1'b0, NO_RES},
		'{CH_4, 1'b0, 1'b0, NO_RES},
		'{CH_COLON, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, pb64_pkg::ST_DECODED}},
		// single top byte passes through
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, pb64_pkg::ST_PASSTHROUGH}},
		// string ends inside the prefix
		'{CH_B, 1'b0, 1'b0, NO_RES},
		'{CH_6, 1'b1, 1'b0, NO_RES},
		// mismatch on the last prefix character replays three held characters
		'{CH_B, 1'b0, 1'b0, NO_RES},
		'{CH_6, 1'b0, 1'b0, NO_RES},
		'{CH_4, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{CH_LOWZ, 1'b1, 1'b1, '{CH_LOWZ, 1'b1, 1'b1, pb64_pkg::ST_PASSTHROUGH}},
		// NUL in the body fails the decode
		'{CH_B, 1'b0, 1'b0, NO_RES},
		'{CH_6, 1'b0, 1'b0, NO_RES},
		'{CH_4, 1'b0, 1'b0, NO_RES},
		'{CH_COLON, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, pb64_pkg::ST_FAILED}},
		// top sextets give 0xFF, then padding, then an ignored character
		'{CH_B, 1'b0, 1'b0, NO_RES},
		'{CH_6, 1'b0, 1'b0, NO_RES},
		'{CH_4, 1'b0, 1'b0, NO_RES},
		'{CH_COLON, 1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{pb64_pkg::PAD_CHAR, 1'b0, 1'b0, NO_RES},
		'{CH_UPA, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, pb64_pkg::ST_DECODED}}
	};

	logic clk;
	logic arst_n;

	pb64_char_if   char_bus ();
	pb64_result_if res_bus ();

	prefixed_base64_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_stream   (char_bus),
		.result_stream (res_bus)
	);

	char_item_t         stim_q[$];
	pb64_pkg::result_t  pending_results[$];
	int unsigned        accepted  = 0;
	int unsigned        err_count = 0;
	bit                 stim_done = 0;

	// Decoder image
	int unsigned pfx_held = 0;
	bit          thru     = 0;
	logic [5:0]  residue  = '0;
	logic [1:0]  phase    = '0;
	bit          pad_seen = 0;
	bit          bad_char = 0;
	bit          emitted  = 0;

	string ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	always #5 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Append one expected result to the tail of the queue
	function automatic void queue_result(input pb64_pkg::result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic int alpha_index(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 8'h41;
		if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 8'h61 + 26;
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30 + 52;
		if (c == 8'h2B) return 62;
		if (c == 8'h2F) return 63;
		return -1;
	endfunction

	// Advance the decoder image by one character and queue the bytes it yields
	task automatic decode_step(input logic [7:0] c, input logic fin);
		int         v;
		logic       have;
		logic [7:0] b;
		logic [5:0] s;
		have = 1'b0;
		b = 8'h00;
		if (thru) begin
			queue_result(pb64_pkg::result_t'{c, 1'b1, fin,
				fin ? pb64_pkg::ST_PASSTHROUGH : pb64_pkg::ST_DECODED});
		end else if (pfx_held < pb64_pkg::PrefixLen) begin
			if (c == pb64_pkg::PREFIX_CHARS[pfx_held]
				&& pfx_held == pb64_pkg::PrefixLen - 1) begin
				pfx_held = pb64_pkg::PrefixLen;
				if (fin)
					queue_result(pb64_pkg::result_t'{8'h00, 1'b0, 1'b1,
						pb64_pkg::ST_DECODED});
			end else if (c == pb64_pkg::PREFIX_CHARS[pfx_held] && !fin) begin
				pfx_held++;
			end else begin
				// replay held prefix characters, then switch to passthrough
				for (int i = 0; i < pfx_held; i++)
					queue_result(pb64_pkg::result_t'{pb64_pkg::PREFIX_CHARS[i], 1'b1,
						1'b0, pb64_pkg::ST_DECODED});
				queue_result(pb64_pkg::result_t'{c, 1'b1, fin,
					fin ? pb64_pkg::ST_PASSTHROUGH : pb64_pkg::ST_DECODED});
				thru = 1;
			end
		end else begin
			if (!pad_seen && !bad_char) begin
				if (c == pb64_pkg::PAD_CHAR) begin
					pad_seen = 1;
				end else begin
					v = alpha_index(c);
					if (v < 0) begin
						bad_char = 1;
					end else begin
						s = 6'(v);
						case (phase)
							2'd0: begin
								residue = s;
							end
							2'd1: begin
								b = {residue, s[5:4]};
								residue = {2'b00, s[3:0]};
								have = 1'b1;
							end
							2'd2: begin
								b = {residue[3:0], s[5:2]};
								residue = {4'b0000, s[1:0]};
								have = 1'b1;
							end
							default: begin
								b = {residue[1:0], s};
								residue = '0;
								have = 1'b1;
							end
						endcase
						phase = phase + 2'd1;
						if (have) emitted = 1;
					end
				end
			end
			if (fin)
				queue_result(pb64_pkg::result_t'{have ? b : 8'h00, have, 1'b1,
					(bad_char || !emitted) ? pb64_pkg::ST_FAILED : pb64_pkg::ST_DECODED});
			else if (have)
				queue_result(pb64_pkg::result_t'{b, 1'b1, 1'b0, pb64_pkg::ST_DECODED});
		end
		if (fin) begin
			pfx_held = 0;
			thru = 0;
			residue = '0;
			phase = '0;
			pad_seen = 0;
			bad_char = 0;
			emitted = 0;
		end
	endtask

	// Sender: directed table, then random strings, in bursts with gaps
	initial begin
		logic [7:0] str[$];
		char_item_t item;
		int         kind;
		int         k;
		int         burst_left;
		char_bus.valid <= 1'b0;
		char_bus.char_code <= 8'h00;
		char_bus.final_char <= 1'b0;

		for (int i = 0; i < DIRECTED_LEN; i++)
			stim_q.insert(stim_q.size(), DIRECTED_ROWS[i]);
		while (stim_q.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
			str.delete();
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				// well-formed prefix with a random body
				for (k = 0; k < pb64_pkg::PrefixLen; k++)
					str.insert(str.size(), pb64_pkg::PREFIX_CHARS[k]);
				repeat ($urandom_range(0, 10))
					str.insert(str.size(), ALPHABET[$urandom_range(0, 63)]);
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 2)) str.insert(str.size(), pb64_pkg::PAD_CHAR);
					if ($urandom_range(0, 1))
						str.insert(str.size(), ALPHABET[$urandom_range(0, 63)]);
				end
				if ($urandom_range(0, 5) == 0)
					str.insert($urandom_range(pb64_pkg::PrefixLen, str.size()),
						8'($urandom_range(0, 255)));
			end else if (kind == 7) begin
				// broken prefix, then plaintext
				k = $urandom_range(0, 3);
				for (int i = 0; i < k; i++) str.insert(str.size(), pb64_pkg::PREFIX_CHARS[i]);
				str.insert(str.size(), 8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 5)) str.insert(str.size(), 8'($urandom_range(0, 255)));
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 6)) str.insert(str.size(), 8'($urandom_range(0, 255)));
			end else begin
				// string cut short inside the prefix
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) str.insert(str.size(), pb64_pkg::PREFIX_CHARS[i]);
			end
			for (k = 0; k < str.size(); k++) begin
				item.code = str[k];
				item.fin = (k == str.size() - 1);
				item.typed = 1'b0;
				item.want = NO_RES;
				stim_q.insert(stim_q.size(), item);
			end
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		burst_left = $urandom_range(5, 40);
		foreach (stim_q[idx]) begin
			if (burst_left == 0) begin
				char_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 15);
			end
			char_bus.valid <= 1'b1;
			char_bus.char_code <= stim_q[idx].code;
			char_bus.final_char <= stim_q[idx].fin;
			@(posedge clk);
			while (!char_bus.ready) @(posedge clk);
			burst_left--;
		end
		char_bus.valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver: stall pattern that changes mode, plus one long hold-off
	initial begin
		int unsigned hold_left;
		int unsigned tick;
		int          mode;
		bit          held_once;
		hold_left = 0;
		tick = 0;
		mode = 0;
		held_once = 0;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 48 == 0) mode = $urandom_range(0, 3);
			if (!held_once && accepted >= 90) begin
				held_once = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				case (mode)
					0:       res_bus.ready <= 1'b1;
					1:       res_bus.ready <= ($urandom_range(0, 3) != 0);
					2:       res_bus.ready <= (tick % 3 == 0);
					default: res_bus.ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	// Check results first, then predict from the character taken at the same edge
	always @(posedge clk) begin
		pb64_pkg::result_t want;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: out_byte %h byte_valid %b last_result %b status %0d",
						res_bus.out_byte, res_bus.byte_valid, res_bus.last_result, res_bus.status);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (res_bus.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, res_bus.out_byte);
						err_count++;
					end
					if (res_bus.byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %b, got %b", want.byte_valid,
							res_bus.byte_valid);
						err_count++;
					end
					if (res_bus.last_result !== want.last_result) begin
						$error("last_result: expected %b, got %b", want.last_result,
							res_bus.last_result);
						err_count++;
					end
					if (res_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_bus.status);
						err_count++;
					end
				end
			end
			if (char_bus.valid && char_bus.ready) begin
				decode_step(char_bus.char_code, char_bus.final_char);
				if (stim_q[accepted].typed) begin
					if (pending_results.size() > 0) void'(pending_results.pop_back());
					queue_result(stim_q[accepted].want);
				end
				accepted++;
			end
		end
	end

	always @(posedge clk) begin
		int unsigned idle;
		if (arst_n) begin
			if ((char_bus.valid && char_bus.ready) || (res_bus.valid && res_bus.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end else begin
			idle = 0;
		end
	end

	initial begin
		wait (stim_done);
		// let the predictor see the last transaction before polling the queue
		repeat (2) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
